// ===== rtl/core/ptm_pkg.sv =====
// Shared types, constants and table functions of the phoneme token mapper.
package ptm_pkg;

   localparam int CODE_W              = 21;
   localparam int BYTE_W              = 8;
   localparam int GROUP_SIZE          = 4;
   localparam int GROUP_CNT_W         = $clog2(GROUP_SIZE + 1);
   localparam int SLOT_W              = $clog2(GROUP_SIZE);
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [BYTE_W-1:0] SPACE_CHAR  = 8'h20;
   localparam logic [BYTE_W-1:0] TAB_CHAR    = 8'h09;
   localparam logic [BYTE_W-1:0] CR_CHAR     = 8'h0D;
   localparam logic [CODE_W-1:0] PAUSE_CODE  = 21'h00005F;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic {
      MODE_TABLE  = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef struct packed {
      byte_type data_byte;
      logic     end_of_text;
   } req_item_type;

   typedef struct packed {
      code_type phoneme_code;
      logic     run_last;
   } rsp_item_type;

   typedef struct packed {
      logic mapping_mode;
   } csr_item_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [GROUP_SIZE-1:0][CODE_W-1:0] codes;
      logic [GROUP_CNT_W-1:0]            count;
   } result_group_type;

   typedef struct packed {
      logic             valid;
      result_group_type grp;
   } group_push_type;

   typedef struct packed {
      logic     hit;
      code_type code;
   } pua_hit_type;

   function automatic logic is_space(input byte_type b);
      return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
   endfunction

   // Private-use table; the key pairs sy/sh, zy/jy and ty/ch each share a code.
   function automatic pua_hit_type pua_lookup(input logic [1:0] len, input byte_type b0,
                                              input byte_type b1);
      pua_hit_type r;
      r.hit  = 1'b1;
      r.code = '0;
      if (len == 2'd1) begin
         unique case (b0)
            "f":     r.code = 21'h00E00F;
            "v":     r.code = 21'h00E011;
            default: r.hit  = 1'b0;
         endcase
      end else if (len == 2'd2) begin
         unique case ({b0, b1})
            "ky":    r.code = 21'h00E000;
            "gy":    r.code = 21'h00E001;
            "sy":    r.code = 21'h00E002;
            "sh":    r.code = 21'h00E002;
            "zy":    r.code = 21'h00E003;
            "jy":    r.code = 21'h00E003;
            "ty":    r.code = 21'h00E004;
            "ch":    r.code = 21'h00E004;
            "dy":    r.code = 21'h00E005;
            "ny":    r.code = 21'h00E006;
            "hy":    r.code = 21'h00E007;
            "by":    r.code = 21'h00E008;
            "py":    r.code = 21'h00E009;
            "my":    r.code = 21'h00E00A;
            "ry":    r.code = 21'h00E00B;
            "ts":    r.code = 21'h00E00C;
            "dz":    r.code = 21'h00E00D;
            "kw":    r.code = 21'h00E00E;
            "gw":    r.code = 21'h00E010;
            "mh":    r.code = 21'h00E013;
            "nh":    r.code = 21'h00E014;
            "nw":    r.code = 21'h00E015;
            default: r.hit  = 1'b0;
         endcase
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ptm_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
interface ptm_stream_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/phoneme_token_mapper.sv =====
// Top level of the phoneme token mapper: text bytes in, phoneme codes out.
//
// Channels: req_ch takes one text byte per item (data_byte, end_of_text);
// rsp_ch gives one phoneme code per item, with run_last set on the last code
// that a given byte caused; csr_ch writes mapping_mode (0 table, 1 decode).
// A byte may cause zero to four codes; a held byte or a blank with no open
// token causes none.
// Path: a byte is held in the input register, its result group is then written
// into the result queue, and its codes leave from the head of that queue.
// Throughput: one byte per cycle while each byte causes at most one code and
// the receiver takes each code; a byte with more codes gives one per handshake.
// The queue holds QUEUE_DEPTH such groups; input flows on while a burst drains.
// Receiver stall: the queue fills, then the input register holds its byte
// and req_ch.ready drops until a group slot frees.
// Reset: synchronous; clears the mode to table mode, closes any open token,
// and empties the queue. Ready on both input ports is low during reset.
// A configuration write also drops the open token without output; write only
// while the block is idle.
module phoneme_token_mapper #(
   parameter int QUEUE_DEPTH = ptm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ptm_stream_if.sink   req_ch,
   ptm_stream_if.source rsp_ch,
   ptm_stream_if.sink   csr_ch
);
   import ptm_pkg::*;

   group_push_type push;
   logic           grp_ready;

   // token state, per-byte mapping, input register
   ptm_token_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .grp_ready (grp_ready),
      .push_out  (push)
   );

   // hold result groups, serialize one code per handshake
   ptm_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .grp_ready (grp_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== rtl/core/ptm_token_core.sv =====
// Input register, token state and per-byte mapping logic.
module ptm_token_core (
   input  logic                    clock,
   input  logic                    reset,
   ptm_stream_if.sink              req_ch,
   ptm_stream_if.sink              csr_ch,
   input  logic                    grp_ready,
   output ptm_pkg::group_push_type push_out
);
   import ptm_pkg::*;

   typedef struct packed {
      logic [GROUP_SIZE-1:0][CODE_W-1:0] codes;
      logic [GROUP_CNT_W-1:0]            count;
      logic [2:0]                        pos;
   } decode_type;

   // Sequence length from the lead byte; zero means skip the byte.
   function automatic logic [2:0] utf8_need(input byte_type c);
      if (!c[7])                    return 3'd1;
      else if (c[7:5] == 3'b110)    return 3'd2;
      else if (c[7:4] == 4'b1110)   return 3'd3;
      else if (c[7:3] == 5'b11110)  return 3'd4;
      else                          return 3'd0;
   endfunction

   // Scan up to four bytes; a non-final scan stops at an incomplete tail.
   function automatic decode_type utf8_run(input logic [3:0][7:0] bytes, input logic [2:0] n,
                                           input logic final_run);
      decode_type r;
      logic [2:0] need;
      logic [2:0] left;
      logic       stop;
      byte_type   c, b1, b2, b3;
      code_type   cp;
      r    = '0;
      stop = 1'b0;
      for (int s = 0; s < GROUP_SIZE; s++) begin
         if (!stop && (r.pos < n)) begin
            c    = bytes[r.pos[1:0]];
            b1   = bytes[2'(r.pos + 3'd1)];
            b2   = bytes[2'(r.pos + 3'd2)];
            b3   = bytes[2'(r.pos + 3'd3)];
            need = utf8_need(c);
            left = n - r.pos;
            if (need == 3'd0) begin
               r.pos = r.pos + 3'd1;
            end else if (left < need) begin
               if (final_run) r.pos = r.pos + 3'd1;
               else           stop  = 1'b1;
            end else begin
               case (need)
                  3'd1:    cp = CODE_W'(c);
                  3'd2:    cp = {10'b0, c[4:0], b1[5:0]};
                  3'd3:    cp = {5'b0, c[3:0], b1[5:0], b2[5:0]};
                  default: cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
               endcase
               if (cp != '0) begin
                  r.codes[r.count[SLOT_W-1:0]] = cp;
                  r.count = r.count + GROUP_CNT_W'(1);
               end
               r.pos = r.pos + need;
            end
         end
      end
      return r;
   endfunction

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   mode_type     mode_ff, mode_in;
   logic         open_ff, open_in;
   logic         committed_ff, committed_in;
   logic [1:0]   held_count_ff, held_count_in;
   logic [2:0][7:0] held_ff, held_in;

   byte_type         b;
   logic             nonws;
   logic             close_tok;
   logic             cm;
   logic             pau_word;
   logic [3:0][7:0]  buf_a;
   logic [2:0]       n;
   logic [2:0]       tail_len;
   decode_type       dec;
   pua_hit_type      pua;
   result_group_type grp;
   logic             advance;
   logic             req_fire;
   logic             csr_fire;

   always_comb begin
      b         = s1_item_ff.data_byte;
      nonws     = !is_space(b);
      buf_a     = {8'h00, held_ff};
      if (nonws) buf_a[held_count_ff] = b;
      n         = {1'b0, held_count_ff} + {2'b0, nonws};
      close_tok = (!nonws || s1_item_ff.end_of_text) && (open_ff || nonws);
      cm        = committed_ff || (nonws && (held_count_ff == 2'd3));
      pau_word  = (n == 3'd3) && (buf_a[0] == "p") && (buf_a[1] == "a") && (buf_a[2] == "u");
      dec       = utf8_run(buf_a, n, close_tok);
      tail_len  = n - dec.pos;
      pua       = pua_lookup(n[1:0], buf_a[0], buf_a[1]);

      grp           = '0;
      open_in       = open_ff || nonws;
      committed_in  = committed_ff;
      held_count_in = held_count_ff;
      held_in       = held_ff;

      if (mode_ff == MODE_TABLE) begin
         if (nonws && committed_ff) begin
            grp.codes[0] = CODE_W'(b);
            grp.count    = GROUP_CNT_W'(1);
         end else if (nonws && (n == 3'd3)) begin
            // past the table window: flush held bytes with this one
            grp.codes[0]  = CODE_W'(buf_a[0]);
            grp.codes[1]  = CODE_W'(buf_a[1]);
            grp.codes[2]  = CODE_W'(buf_a[2]);
            grp.count     = GROUP_CNT_W'(3);
            committed_in  = 1'b1;
            held_count_in = 2'd0;
         end else if (!committed_ff) begin
            if (close_tok) begin
               if (pua.hit) begin
                  grp.codes[0] = pua.code;
                  grp.count    = GROUP_CNT_W'(1);
               end else begin
                  grp.codes[0] = CODE_W'(buf_a[0]);
                  grp.codes[1] = CODE_W'(buf_a[1]);
                  grp.count    = GROUP_CNT_W'(n);
               end
            end else if (nonws) begin
               held_in       = buf_a[2:0];
               held_count_in = n[1:0];
            end
         end
      end else begin
         if (close_tok) begin
            if (!cm && ((n == 3'd1) || pau_word)) begin
               grp.codes[0] = (n == 3'd1) ? CODE_W'(buf_a[0]) : PAUSE_CODE;
               grp.count    = GROUP_CNT_W'(1);
            end else begin
               grp.codes = dec.codes;
               grp.count = dec.count;
            end
         end else if (nonws) begin
            if (cm) begin
               grp.codes     = dec.codes;
               grp.count     = dec.count;
               committed_in  = 1'b1;
               held_in[0]    = buf_a[2'(dec.pos)];
               held_in[1]    = buf_a[2'(dec.pos + 3'd1)];
               held_in[2]    = buf_a[2'(dec.pos + 3'd2)];
               held_count_in = tail_len[1:0];
            end else begin
               held_in       = buf_a[2:0];
               held_count_in = n[1:0];
            end
         end
      end

      // close the token: drop all held state
      if (close_tok) begin
         open_in       = 1'b0;
         committed_in  = 1'b0;
         held_count_in = 2'd0;
      end
   end

   assign advance        = s1_valid_ff && ((grp.count == '0) || grp_ready);
   assign req_ch.ready   = !reset && (!s1_valid_ff || advance);
   assign csr_ch.ready   = !reset;
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign csr_fire       = csr_ch.valid && csr_ch.ready;
   assign push_out.valid = advance && (grp.count != '0);
   assign push_out.grp   = grp;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_ch.payload;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      mode_in = mode_ff;
      if (csr_fire) mode_in = mode_type'(csr_ch.payload.mapping_mode);
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (advance) held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         mode_ff       <= MODE_TABLE;
         open_ff       <= 1'b0;
         committed_ff  <= 1'b0;
         held_count_ff <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mode_ff     <= mode_in;
         if (csr_fire) begin
            open_ff       <= 1'b0;
            committed_ff  <= 1'b0;
            held_count_ff <= 2'd0;
         end else if (advance) begin
            open_ff       <= open_in;
            committed_ff  <= committed_in;
            held_count_ff <= held_count_in;
         end
      end
   end

endmodule

// ===== rtl/core/ptm_result_queue.sv =====
// Result group queue and serializer, one result per cycle while rsp_ch is ready.
module ptm_result_queue #(
   parameter int DEPTH = ptm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ptm_pkg::group_push_type push_in,
   output logic                    grp_ready,
   ptm_stream_if.source            rsp_ch
);
   import ptm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   result_group_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   result_group_type        head;
   logic                    last_slot;
   logic                    pop_fire;
   logic                    pop_grp;

   assign head      = mem_ff[rd_ptr_ff];
   assign last_slot = ({1'b0, slot_ff} == (head.count - GROUP_CNT_W'(1)));
   assign grp_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_fire  = rsp_ch.valid && rsp_ch.ready;
   assign pop_grp   = pop_fire && last_slot;

   assign rsp_ch.valid                = (count_ff != '0);
   assign rsp_ch.payload.phoneme_code = head.codes[slot_ff];
   assign rsp_ch.payload.run_last     = last_slot;

   always_comb begin
      wr_ptr_in = push_in.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_grp ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_in.valid) - CNT_W'(pop_grp);
      slot_in   = slot_ff;
      if (pop_grp)       slot_in = '0;
      else if (pop_fire) slot_in = slot_ff + SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push_in.valid) mem_ff[wr_ptr_ff] <= push_in.grp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         slot_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
      end
   end

endmodule

// ===== rtl/core/ptm_checker.sv =====
// Port-level checks of the phoneme token mapper, bound to the top level.
module ptm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_last,
   input logic [ptm_pkg::CODE_W-1:0]  rsp_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) && $stable(rsp_last))
      else $error("stalled result changed or dropped");

   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("result burst ended before its last item");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without an item two cycles earlier");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_block: assert property (@(posedge clock)
      reset |-> !req_ready)
      else $error("input ready during reset");

endmodule

bind phoneme_token_mapper ptm_checker u_ptm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.payload.run_last),
   .rsp_code  (rsp_ch.payload.phoneme_code)
);
